// ===== src/modular_polynomial_evaluator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the modular polynomial evaluator
// Clocked, reset-qualified property checks; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef MODULAR_POLYNOMIAL_EVALUATOR_ASSERT_SVH
`define MODULAR_POLYNOMIAL_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPE_ASSERT_NOW(lbl, ante, cons, msg)
`define MPE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/mpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mpe_pkg
// Shared types and constants of the modular polynomial evaluator.
// ----------------------------------------------------------------------------
package mpe_pkg;
  localparam int unsigned MaxTerms   = 16;
  localparam int unsigned CoeffWidth = 32;
  localparam int unsigned IdxW       = $clog2(MaxTerms);
  localparam int unsigned ModW       = 31;
  localparam int unsigned WideW      = 64;
  localparam int unsigned MagW       = WideW - 1;
  localparam int unsigned CntW       = $clog2(MagW + 1);

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdEval  = 1'b1;

  typedef struct packed {
    logic                         cmd;
    logic [IdxW-1:0]              index;
    logic signed [CoeffWidth-1:0] operand;
  } in_t;

  typedef struct packed {
    logic signed [CoeffWidth-1:0] value;
    logic                         status;
    logic [IdxW-1:0]              degree;
  } out_t;
endpackage

// ===== src/modular_polynomial_evaluator.sv =====
// ----------------------------------------------------------------------------
// modular_polynomial_evaluator
// Coefficient table with Horner evaluation mod p or wrapping at 32 bits.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A write beat (cmd 0) stores the operand at
// index, reduced into 0..p-1 when the modulus is nonzero, and returns the
// stored value and the new degree. An evaluate beat (cmd 1) runs Horner's
// rule from the degree down to index 0. With a nonzero modulus each step
// multiplies, then launches the bit-serial remainder unit, which shifts
// through the dividend magnitude and then signals done. With a nonzero
// modulus, an x outside 0..p-1 returns status 1, value 0 at once.
// The result shows up in the same cycle in which the next beat can be
// taken. The block takes no beat until the current one is handed to the
// output register, so a stalled receiver stalls the input. Write the
// modulus only while idle.
`include "modular_polynomial_evaluator_assert.svh"
module modular_polynomial_evaluator
  import mpe_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [ModW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_t             in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_t            out_data_o
);
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_RED  = 5'b00100,
    ST_REM  = 5'b01000,
    ST_OUT  = 5'b10000
  } st_e;

  st_e st_q, st_d;
  logic [ModW-1:0]              mod_q;
  logic                         cmd_q;
  logic [IdxW-1:0]              idx_q, idx_d;
  logic [CoeffWidth-1:0]        x_q, x_d, y_q, y_d;
  logic signed [WideW-1:0]      t_q, t_d;
  logic                         stat_q, stat_d;
  logic                         out_valid_q;
  out_t                         out_q;

  logic                         accept, out_free;
  logic                         rem_start, rem_done;
  logic signed [WideW-1:0]      rem_dividend;
  logic [ModW-1:0]              rem_result;
  logic                         st_we;
  logic [IdxW-1:0]              st_waddr;
  logic signed [CoeffWidth-1:0] st_wdata, coef;
  logic [IdxW-1:0]              degree;
  logic [WideW-1:0]             mul_w;
  logic                         x_bad;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (st_q == ST_IDLE);
  assign x_bad = in_data_i.operand[CoeffWidth-1] ||
                 (in_data_i.operand[ModW-1:0] >= mod_q);
  assign mul_w = {32'b0, y_q} * {32'b0, x_q};

  mpe_rem u_rem (
    .clk_i, .rst_ni,
    .start_i(rem_start), .dividend_i(rem_dividend), .modulus_i(mod_q),
    .done_o(rem_done), .result_o(rem_result)
  );

  mpe_coef_store u_store (
    .clk_i, .rst_ni,
    .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(idx_q), .rdata_o(coef), .degree_o(degree)
  );

  always_comb begin
    st_d = st_q; idx_d = idx_q; x_d = x_q; y_d = y_q; t_d = t_q; stat_d = stat_q;
    rem_start = 1'b0;
    rem_dividend = WideW'(signed'(in_data_i.operand));
    st_we = 1'b0; st_waddr = idx_q; st_wdata = signed'(CoeffWidth'(rem_result));
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d = in_data_i.index; x_d = in_data_i.operand; stat_d = 1'b0;
          if (in_data_i.cmd == CmdWrite) begin
            if (mod_q == '0) begin
              st_we = 1'b1; st_waddr = in_data_i.index; st_wdata = in_data_i.operand;
              y_d = in_data_i.operand; st_d = ST_OUT;
            end else begin
              rem_start = 1'b1; st_d = ST_REM;
            end
          end else if (mod_q != '0 && x_bad) begin
            stat_d = 1'b1; y_d = '0; st_d = ST_OUT;
          end else begin
            idx_d = degree; y_d = '0; st_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        t_d = signed'(mul_w + WideW'(coef));
        st_d = ST_RED;
      end
      ST_RED: begin
        if (mod_q == '0) begin
          y_d = t_q[CoeffWidth-1:0];
          if (idx_q == '0) st_d = ST_OUT;
          else begin
            idx_d = idx_q - 1'b1; st_d = ST_MUL;
          end
        end else begin
          rem_dividend = t_q; rem_start = 1'b1; st_d = ST_REM;
        end
      end
      ST_REM: begin
        if (rem_done) begin
          y_d = CoeffWidth'(rem_result);
          if (cmd_q == CmdWrite) begin
            st_we = 1'b1; st_d = ST_OUT;
          end else if (idx_q == '0) st_d = ST_OUT;
          else begin
            idx_d = idx_q - 1'b1; st_d = ST_MUL;
          end
        end
      end
      ST_OUT: begin
        if (out_free) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      mod_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) mod_q <= cfg_data_i;
      if (st_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)           out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; x_q <= x_d; y_q <= y_d; t_q <= t_d; stat_q <= stat_d;
    if (accept) cmd_q <= in_data_i.cmd;
    if (st_q == ST_OUT && out_free) begin
      out_q.value  <= signed'(y_q);
      out_q.status <= stat_q;
      out_q.degree <= degree;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MPE_ASSERT_NOW(a_rem_in_rem, rem_done, st_q == ST_REM, "remainder done outside REM")
  `MPE_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready_o, "ready right after accept")
  `MPE_ASSERT_NOW(a_bad_x_zero, out_valid_o && out_data_o.status,
                  out_data_o.value == '0, "out-of-range point with nonzero value")
endmodule

// ===== src/mpe_rem.sv =====
// ----------------------------------------------------------------------------
// mpe_rem
// Bit-serial restoring remainder: signed 64-bit dividend mod a 31-bit
// modulus, result in 0..p-1. One dividend bit per cycle.
// ----------------------------------------------------------------------------
module mpe_rem
  import mpe_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [WideW-1:0] dividend_i,
  input  logic [ModW-1:0]         modulus_i,
  output logic                    done_o,
  output logic [ModW-1:0]         result_o
);
  logic            busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;
  logic [MagW-1:0] mag_q, mag_d;
  logic [ModW-1:0] rem_q, rem_d;
  logic [ModW:0]   shifted;

  assign shifted = {rem_q, mag_q[MagW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(MagW - 1);
      neg_d  = dividend_i[WideW-1];
      mag_d  = dividend_i[WideW-1] ? MagW'(-dividend_i) : MagW'(dividend_i);
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ModW'((shifted >= {1'b0, modulus_i}) ? shifted - {1'b0, modulus_i}
                                                   : shifted);
      mag_d = {mag_q[MagW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
  end

  // negative dividend: fold a nonzero remainder back into 0..p-1
  assign done_o   = done_q;
  assign result_o = (neg_q && rem_q != '0) ? modulus_i - rem_q : rem_q;
endmodule

// ===== src/mpe_coef_store.sv =====
// ----------------------------------------------------------------------------
// mpe_coef_store
// Coefficient registers with nonzero flags and degree encoder.
// ----------------------------------------------------------------------------
module mpe_coef_store
  import mpe_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [IdxW-1:0]              waddr_i,
  input  logic signed [CoeffWidth-1:0] wdata_i,
  input  logic [IdxW-1:0]              raddr_i,
  output logic signed [CoeffWidth-1:0] rdata_o,
  output logic [IdxW-1:0]              degree_o
);
  logic signed [CoeffWidth-1:0] coef_q [MaxTerms];
  logic [MaxTerms-1:0]          nz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q <= '0;
      for (int i = 0; i < MaxTerms; i++) coef_q[i] <= '0;
    end else if (we_i) begin
      coef_q[waddr_i] <= wdata_i;
      nz_q[waddr_i]   <= (wdata_i != '0);
    end
  end

  assign rdata_o = coef_q[raddr_i];

  always_comb begin
    degree_o = '0;
    for (int i = 0; i < MaxTerms; i++)
      if (nz_q[i]) degree_o = IdxW'(i);
  end
endmodule
